// File: rtl/smq_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the selective mailbox queue.
// Used by the top level; no dependencies.
package smq_pkg;

    // One stored message as it sits in the mailbox memory.
    typedef struct packed {
        logic [15:0] recipient;
        logic [15:0] sender;
        logic [7:0]  content;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    // Command modes.
    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_SHIFT  = 3'b100
    } t_state;

endpackage

// File: rtl/smq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module smq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/selective_mailbox_queue_core.sv
`timescale 1ns / 1ps
// Top level of the selective mailbox queue: command control, scan and compaction.
// Depends on smq_pkg and smq_ram.
//
//  Channel   | Handshake             | Word
//  ----------+-----------------------+--------------------------------------------
//  command   | i_start, o_busy       | i_mode, i_caller_id, i_recipient_id, i_content
//  result    | o_valid (one cycle)   | o_status, o_msg_sender, o_msg_content,
//            |                       | o_wake_valid, o_wake_id
//
// For a send, a failed send and a receive on an empty mailbox, the result word appears
// the cycle after the command is accepted and o_busy stays low.
// A receive scans the memory at one read per cycle from the oldest message, then moves
// the younger messages down one slot at one read and one write per cycle.
// Reset empties the mailbox at once; the entries need no clearing pass.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module selective_mailbox_queue_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [15:0] i_caller_id,
    input  logic [15:0] i_recipient_id,
    input  logic [7:0]  i_content,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_msg_sender,
    output logic [7:0]  o_msg_content,
    output logic        o_wake_valid,
    output logic [15:0] o_wake_id
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    smq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ra, n_ra;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    logic [15:0]     r_key, n_key;
    logic [15:0]     r_snd, n_snd;
    logic [7:0]      r_cnt, n_cnt;

    logic            r_valid, n_valid;
    logic [1:0]      r_status, n_status;
    logic [15:0]     r_msg_sender, n_msg_sender;
    logic [7:0]      r_msg_content, n_msg_content;
    logic            r_wake_valid, n_wake_valid;
    logic [15:0]     r_wake_id, n_wake_id;

    logic            accept;
    logic            rd_en;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    smq_pkg::t_entry mem_wdata;
    smq_pkg::t_entry mem_rdata;
    logic [smq_pkg::ENTRY_W-1:0] rdata_bits;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != smq_pkg::S_IDLE);

    // A scan or shift read is issued while the read pointer is below the fill count.
    assign rd_en = (r_state != smq_pkg::S_IDLE) && (r_ra < r_count);

    smq_ram #(
        .WIDTH(smq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (rd_en),
        .i_raddr(r_ra[AW-1:0]),
        .o_rdata(rdata_bits)
    );

    assign mem_rdata = smq_pkg::t_entry'(rdata_bits);

    // Write port: append on a send, move a message down one slot while shifting.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = '{recipient: i_recipient_id, sender: i_caller_id, content: i_content};
        if (r_state == smq_pkg::S_IDLE) begin
            mem_we = accept && (i_mode == smq_pkg::MODE_SEND) && (r_count != FULL_COUNT);
        end else if (r_state == smq_pkg::S_SHIFT) begin
            mem_we    = r_pend;
            mem_waddr = r_pidx - 1'b1;
            mem_wdata = mem_rdata;
        end
    end

    // Control: command decode, scan for the oldest match, then compaction.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ra          = r_ra;
        n_pidx        = r_pidx;
        n_pend        = 1'b0;
        n_key         = r_key;
        n_snd         = r_snd;
        n_cnt         = r_cnt;
        n_valid       = 1'b0;
        n_status      = r_status;
        n_msg_sender  = r_msg_sender;
        n_msg_content = r_msg_content;
        n_wake_valid  = r_wake_valid;
        n_wake_id     = r_wake_id;

        // Read pipeline shared by scan and shift.
        if (rd_en) begin
            n_ra   = r_ra + 1'b1;
            n_pend = 1'b1;
            n_pidx = r_ra[AW-1:0];
        end

        unique case (r_state)
            smq_pkg::S_IDLE: begin
                if (accept) begin
                    n_msg_sender  = '0;
                    n_msg_content = '0;
                    n_wake_valid  = 1'b0;
                    n_wake_id     = '0;
                    if (i_mode == smq_pkg::MODE_SEND) begin
                        n_valid = 1'b1;
                        if (r_count == FULL_COUNT) begin
                            n_status = smq_pkg::ST_FULL;
                        end else begin
                            n_status     = smq_pkg::ST_OK;
                            n_count      = r_count + 1'b1;
                            n_wake_valid = 1'b1;
                            n_wake_id    = i_recipient_id;
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = smq_pkg::ST_NONE;
                    end else begin
                        n_state = smq_pkg::S_SEARCH;
                        n_key   = i_caller_id;
                        n_ra    = '0;
                    end
                end
            end
            smq_pkg::S_SEARCH: begin
                if (r_pend && (mem_rdata.recipient == r_key)) begin
                    // Oldest match found; the reads already in flight feed the shift.
                    n_snd   = mem_rdata.sender;
                    n_cnt   = mem_rdata.content;
                    n_state = smq_pkg::S_SHIFT;
                end else if (!r_pend && !rd_en) begin
                    n_valid       = 1'b1;
                    n_status      = smq_pkg::ST_NONE;
                    n_msg_sender  = '0;
                    n_msg_content = '0;
                    n_wake_valid  = 1'b0;
                    n_wake_id     = '0;
                    n_state       = smq_pkg::S_IDLE;
                end
            end
            smq_pkg::S_SHIFT: begin
                if (!r_pend && !rd_en) begin
                    n_count       = r_count - 1'b1;
                    n_valid       = 1'b1;
                    n_status      = smq_pkg::ST_OK;
                    n_msg_sender  = r_snd;
                    n_msg_content = r_cnt;
                    n_wake_valid  = 1'b0;
                    n_wake_id     = '0;
                    n_state       = smq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smq_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ra          <= n_ra;
        r_pidx        <= n_pidx;
        r_key         <= n_key;
        r_snd         <= n_snd;
        r_cnt         <= n_cnt;
        r_status      <= n_status;
        r_msg_sender  <= n_msg_sender;
        r_msg_content <= n_msg_content;
        r_wake_valid  <= n_wake_valid;
        r_wake_id     <= n_wake_id;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_msg_sender  = r_msg_sender;
    assign o_msg_content = r_msg_content;
    assign o_wake_valid  = r_wake_valid;
    assign o_wake_id     = r_wake_id;

`ifndef SYNTH
    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("mailbox fill count exceeds capacity");

    // A full report only comes from a mailbox that is full.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == smq_pkg::ST_FULL)) |-> (r_count == FULL_COUNT))
        else $error("full reported on a mailbox with room");

    // Shift writes stay inside the held messages.
    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == smq_pkg::S_SHIFT)) |-> (CW'(mem_waddr) < r_count))
        else $error("shift write beyond held messages");

    // A result word never appears while a receive is still in progress.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == smq_pkg::S_IDLE))
        else $error("result word while busy");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selective mailbox queue core: directed table, then random words.
// Depends on smq_pkg and selective_mailbox_queue_core; reads no files.
module testbench;

    localparam int DEPTH            = 32;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 232;
    localparam int DIR_ROWS         = 23;

    // One result word as the block reports it.
    typedef struct packed {
        smq_pkg::t_status status;
        logic [15:0]      sender;
        logic [7:0]       content;
        logic             wake_valid;
        logic [15:0]      wake_id;
    } t_result;

    // One row of the directed table; exp is used only where typed is set.
    typedef struct packed {
        logic        mode;
        logic [15:0] caller;
        logic [15:0] recip;
        logic [7:0]  content;
        logic        typed;
        t_result     exp;
    } t_dir_row;

    localparam t_result RES_NONE = '{smq_pkg::ST_NONE, 16'h0000, 8'h00, 1'b0, 16'h0000};

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_start        = 1'b0;
    logic        i_mode         = smq_pkg::MODE_SEND;
    logic [15:0] i_caller_id    = 16'h0000;
    logic [15:0] i_recipient_id = 16'h0000;
    logic [7:0]  i_content      = 8'h00;
    logic        o_busy;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_msg_sender;
    logic [7:0]  o_msg_content;
    logic        o_wake_valid;
    logic [15:0] o_wake_id;

    // Shadow copy of the mailbox contents, kept in arrival order.
    logic [15:0] mb_recipient [DEPTH];
    logic [15:0] mb_sender [DEPTH];
    logic [7:0]  mb_content [DEPTH];
    int          mb_count = 0;

    t_result     pending_results [$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    // Directed words: empty mailbox, field extremes, self-send, ignored send fields on a
    // receive, and removal of the oldest match at the head and at the tail of the queue with order kept.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{smq_pkg::MODE_RECV, 16'h0000, 16'h0000, 8'h00, 1'b1, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'h0000, 16'hFFFF, 8'hFF, 1'b1,
            '{smq_pkg::ST_OK, 16'h0000, 8'h00, 1'b1, 16'hFFFF}},
        '{smq_pkg::MODE_SEND, 16'hFFFF, 16'h0000, 8'h00, 1'b1,
            '{smq_pkg::ST_OK, 16'h0000, 8'h00, 1'b1, 16'h0000}},
        '{smq_pkg::MODE_SEND, 16'h1234, 16'h1234, 8'h5A, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0001, 16'h0000, 8'h00, 1'b1, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h1234, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'hFFFF, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0000, 16'hFFFF, 8'hFF, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0000, 16'h0000, 8'h00, 1'b1, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'hA5A5, 16'h0011, 8'h01, 1'b0, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'h5A5A, 16'h0022, 8'h02, 1'b0, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'h0F0F, 16'h0011, 8'h03, 1'b0, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'hF0F0, 16'h0033, 8'h04, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0011, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0033, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0011, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0022, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0022, 16'h0000, 8'h00, 1'b1, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'h8000, 16'h8000, 8'h80, 1'b0, RES_NONE},
        '{smq_pkg::MODE_SEND, 16'h0001, 16'h0001, 8'h7F, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h0001, 16'h0000, 8'h00, 1'b0, RES_NONE},
        '{smq_pkg::MODE_RECV, 16'h8000, 16'h0000, 8'h00, 1'b0, RES_NONE}
    };

    selective_mailbox_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_mode        (i_mode),
        .i_caller_id   (i_caller_id),
        .i_recipient_id(i_recipient_id),
        .i_content     (i_content),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_msg_sender  (o_msg_sender),
        .o_msg_content (o_msg_content),
        .o_wake_valid  (o_wake_valid),
        .o_wake_id     (o_wake_id)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one command to the shadow mailbox and returns the word it should produce.
    function automatic t_result mailbox_apply(input logic mode, input logic [15:0] caller,
                                              input logic [15:0] recip, input logic [7:0] cont);
        t_result res;
        int      hit;
        res = '{smq_pkg::ST_OK, 16'h0000, 8'h00, 1'b0, 16'h0000};
        if (mode == smq_pkg::MODE_SEND) begin
            if (mb_count >= DEPTH) begin
                res.status = smq_pkg::ST_FULL;
            end else begin
                mb_recipient[mb_count] = recip;
                mb_sender[mb_count]    = caller;
                mb_content[mb_count]   = cont;
                mb_count++;
                res.wake_valid = 1'b1;
                res.wake_id    = recip;
            end
        end else begin
            // Scan from the youngest down so the oldest match wins.
            hit = -1;
            for (int i = mb_count - 1; i >= 0; i--) begin
                if (mb_recipient[i] == caller) hit = i;
            end
            if (hit < 0) begin
                res.status = smq_pkg::ST_NONE;
            end else begin
                res.sender  = mb_sender[hit];
                res.content = mb_content[hit];
                for (int i = hit; i + 1 < mb_count; i++) begin
                    mb_recipient[i] = mb_recipient[i + 1];
                    mb_sender[i]    = mb_sender[i + 1];
                    mb_content[i]   = mb_content[i + 1];
                end
                mb_count--;
            end
        end
        return res;
    endfunction

    // Presents one command word and holds it until the block takes it.
    task automatic drive_word(input logic mode, input logic [15:0] caller,
                              input logic [15:0] recip, input logic [7:0] cont,
                              input logic typed, input t_result typed_res);
        t_result res;
        i_start        <= 1'b1;
        i_mode         <= mode;
        i_caller_id    <= caller;
        i_recipient_id <= recip;
        i_content      <= cont;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        res = mailbox_apply(mode, caller, recip, cont);
        if (typed) res = typed_res;
        pending_results.push_back(res);
    endtask

    // Random idle cycles before a word; the command fields carry junk meanwhile.
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            i_start        <= 1'b0;
            i_mode         <= 1'($urandom_range(1));
            i_caller_id    <= 16'($urandom);
            i_recipient_id <= 16'($urandom);
            i_content      <= 8'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Lowers start and waits until every outstanding result word has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [15:0] pick_id();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result checker: every result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: status %h sender %h content %h",
                         $time, o_status, o_msg_sender, o_msg_content);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("msg_sender", 32'(want.sender), 32'(o_msg_sender));
                check_field("msg_content", 32'(want.content), 32'(o_msg_content));
                check_field("wake_valid", 32'(want.wake_valid), 32'(o_wake_valid));
                check_field("wake_id", 32'(want.wake_id), 32'(o_wake_id));
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no word moving either way.
    always @(posedge i_clk) begin
        if ((i_start && o_busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases with different idle rates.
    initial begin
        logic        filling;
        logic        mode;
        logic [15:0] caller;
        logic [15:0] recip;
        logic [7:0]  cont;
        logic [15:0] id_pool [4];
        int          idle_pct;
        int          pick;

        filling = 1'b1;
        for (int k = 0; k < 4; k++) id_pool[k] = pick_id();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            drive_word(dir_rows[r].mode, dir_rows[r].caller, dir_rows[r].recip,
                       dir_rows[r].content, dir_rows[r].typed, dir_rows[r].exp);
        end

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 79 : (phase == 3) ? 26 : 0;
            drain_results();
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                idle_gap(idle_pct);

                // Alternate between filling the mailbox (past full) and draining it.
                if (filling && mb_count == DEPTH && $urandom_range(3) == 0) begin
                    filling = 1'b0;
                end else if (!filling && mb_count == 0 && $urandom_range(3) == 0) begin
                    filling = 1'b1;
                    for (int k = 0; k < 4; k++) id_pool[k] = pick_id();
                end else if ($urandom_range(59) == 0) begin
                    filling = ~filling;
                end

                mode   = ($urandom_range(99) < (filling ? 85 : 15)) ? smq_pkg::MODE_SEND
                                                                     : smq_pkg::MODE_RECV;
                caller = 16'($urandom);
                recip  = 16'($urandom);
                cont   = 8'($urandom);
                if (mode == smq_pkg::MODE_SEND) begin
                    // Mostly a small set of recipients, so several messages share one.
                    if ($urandom_range(19) != 0) recip = id_pool[$urandom_range(3)];
                end else begin
                    pick = $urandom_range(9);
                    if (pick < 6) begin
                        caller = id_pool[$urandom_range(3)];
                    end else if (pick < 9 && mb_count > 0) begin
                        caller = mb_recipient[$urandom_range(mb_count - 1)];
                    end
                end
                drive_word(mode, caller, recip, cont, 1'b0, RES_NONE);
            end
        end

        drain_results();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/smq_pkg.sv
rtl/smq_ram.sv
rtl/selective_mailbox_queue_core.sv
tb/testbench.sv
